>>> rtl/core/ims_pkg.sv
// Shared types and constants for the Ising Metropolis spin update block.
// Holds the stream word layout, request kinds, register indexes and the
// command and status structs between controller and datapath.
`timescale 1ns / 1ps

package ims_pkg;

   // Request kinds carried on req_tuser
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_FLIP = 1'b1;

   // Field widths
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int DRAW_W     = 16;
   localparam int PROB_W     = 16;
   localparam int SIDE_CFG_W = 7;
   localparam int DE_W       = 5;

   // Request word layout, lowest bit up
   localparam int REQ_DATA_W   = 32;
   localparam int REQ_ROW_LSB  = 0;
   localparam int REQ_COL_LSB  = 6;
   localparam int REQ_SPIN_BIT = 12;
   localparam int REQ_DRAW_LSB = 13;

   // Response word layout, lowest bit up
   localparam int RSP_DATA_W = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LATTICE_SIDE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_PROB_DE4 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_PROB_DE8 = 2'd2;

   localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = 7'd64;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic sel_down;
      logic latch_up;
      logic commit;
   } ims_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } ims_status_type;

endpackage

>>> rtl/core/ims_ctrl.sv
// Controller for the Ising Metropolis spin update block.
// Sequences the lattice clearing pass, row reads and commit; uses ims_pkg.
`timescale 1ns / 1ps

module ims_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  ims_pkg::ims_status_type status,
   output ims_pkg::ims_cmd_type    cmd
);
   import ims_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RD1   = 3'd2;
   localparam logic [2:0] ST_RD2   = 3'd3;
   localparam logic [2:0] ST_EVAL  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_RD1;
            end
         end
         ST_RD1: begin
            state_in = ST_RD2;
         end
         ST_RD2: begin
            cmd.sel_down = 1'b1;
            cmd.latch_up = 1'b1;
            state_in     = ST_EVAL;
         end
         ST_EVAL: begin
            // hold the down row on port B until the result register frees
            cmd.sel_down = 1'b1;
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("commit issued while result register occupied");

   a_capture_starts_read: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_RD1))
      else $error("captured word did not start the row reads");

   a_commit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> req_tready)
      else $error("block not ready after commit");

   a_clear_then_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.clear_step && status.clear_last) |=> !cmd.clear_step)
      else $error("clearing pass ran past the last row");

endmodule

>>> rtl/core/ims_datapath.sv
// Datapath for the Ising Metropolis spin update block: configuration
// registers, row-wide spin memory, energy and acceptance logic, result register.
// Depends on ims_pkg; driven by ims_ctrl.
`timescale 1ns / 1ps

module ims_datapath #(
   parameter int MAX_SIDE = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ims_pkg::ims_cmd_type              cmd,
   output ims_pkg::ims_status_type           status,
   input  logic                              req_tuser,
   input  logic [ims_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              csr_we,
   input  logic [ims_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ims_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ims_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import ims_pkg::*;

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CW     = (SIDE_W > SIDE_CFG_W) ? SIDE_W : SIDE_CFG_W;
   localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

   // configuration registers
   logic [SIDE_CFG_W-1:0] side_ff;
   logic [PROB_W-1:0]     prob4_ff;
   logic [PROB_W-1:0]     prob8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= SIDE_RESET;
         prob4_ff <= '0;
         prob8_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LATTICE_SIDE:    side_ff  <= csr_wdata[SIDE_CFG_W-1:0];
            CSR_ACCEPT_PROB_DE4: prob4_ff <= csr_wdata[PROB_W-1:0];
            CSR_ACCEPT_PROB_DE8: prob8_ff <= csr_wdata[PROB_W-1:0];
            default: ;
         endcase
      end
   end

   // captured request word
   logic              kind_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic              spin_ff;
   logic [DRAW_W-1:0] draw_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_tuser;
         row_ff  <= req_tdata[REQ_ROW_LSB +: ROW_W];
         col_ff  <= req_tdata[REQ_COL_LSB +: COL_W];
         spin_ff <= req_tdata[REQ_SPIN_BIT];
         draw_ff <= req_tdata[REQ_DRAW_LSB +: DRAW_W];
      end
   end

   // side in use and wrapped neighbour indexes
   logic [CW-1:0] side_raw, side_use, row_x, col_x;
   logic [CW-1:0] up_x, down_x, left_x, right_x;
   logic          in_range;

   always_comb begin
      side_raw = CW'(side_ff);
      if (side_raw < CW'(2)) begin
         side_use = CW'(2);
      end else if (side_raw > CW'(MAX_SIDE)) begin
         side_use = CW'(MAX_SIDE);
      end else begin
         side_use = side_raw;
      end
      row_x    = CW'(row_ff);
      col_x    = CW'(col_ff);
      in_range = (row_x < side_use) && (col_x < side_use);
      up_x     = (row_x == '0) ? side_use - CW'(1) : row_x - CW'(1);
      down_x   = (row_x + CW'(1) == side_use) ? '0 : row_x + CW'(1);
      left_x   = (col_x == '0) ? side_use - CW'(1) : col_x - CW'(1);
      right_x  = (col_x + CW'(1) == side_use) ? '0 : col_x + CW'(1);
   end

   logic [ADDR_W-1:0] row_idx, col_idx, left_idx, right_idx;
   assign row_idx   = row_x[ADDR_W-1:0];
   assign col_idx   = col_x[ADDR_W-1:0];
   assign left_idx  = left_x[ADDR_W-1:0];
   assign right_idx = right_x[ADDR_W-1:0];

   // clearing pass counter
   logic [ADDR_W-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
      end
   end

   assign status.clear_last = (clr_cnt_ff == ADDR_W'(MAX_SIDE - 1));

   // row-wide spin memory: port A reads the site row, port B up then down
   logic [MAX_SIDE-1:0] row_mem_ff [MAX_SIDE];
   logic [MAX_SIDE-1:0] rd_a_ff, rd_b_ff;
   logic [ADDR_W-1:0]   rd_b_addr;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [MAX_SIDE-1:0] mem_wdata;

   assign rd_b_addr = cmd.sel_down ? down_x[ADDR_W-1:0] : up_x[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= row_mem_ff[row_idx];
      rd_b_ff <= row_mem_ff[rd_b_addr];
   end

   logic up_bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_up) begin
         up_bit_ff <= rd_b_ff[col_idx];
      end
   end

   // energy change and acceptance
   logic            centre;
   logic [2:0]      up_count;
   logic signed [DE_W-1:0] de;
   logic            de_nonpos, de_is4, acc;

   always_comb begin
      centre   = rd_a_ff[col_idx];
      up_count = {2'b00, up_bit_ff} + {2'b00, rd_b_ff[col_idx]}
               + {2'b00, rd_a_ff[left_idx]} + {2'b00, rd_a_ff[right_idx]};
      // dE = 2*s*(2*count - 4)
      case ({centre, up_count})
         {1'b1, 3'd0}: de = -5'sd8;
         {1'b1, 3'd1}: de = -5'sd4;
         {1'b1, 3'd3}: de = 5'sd4;
         {1'b1, 3'd4}: de = 5'sd8;
         {1'b0, 3'd0}: de = 5'sd8;
         {1'b0, 3'd1}: de = 5'sd4;
         {1'b0, 3'd3}: de = -5'sd4;
         {1'b0, 3'd4}: de = -5'sd8;
         default:      de = 5'sd0;
      endcase
      de_nonpos = (de <= 5'sd0);
      de_is4    = (de == 5'sd4);
      if (de_nonpos) begin
         acc = 1'b1;
      end else if (de_is4) begin
         acc = (draw_ff <= prob4_ff);
      end else begin
         acc = (draw_ff <= prob8_ff);
      end
   end

   // write-back row and result word
   logic                  is_load, new_spin, spin_after, acc_out;
   logic signed [DE_W-1:0] de_out;
   logic [MAX_SIDE-1:0]   new_row;

   always_comb begin
      is_load  = (kind_ff == REQ_LOAD);
      new_spin = is_load ? spin_ff : ~centre;
      new_row  = rd_a_ff;
      new_row[col_idx] = new_spin;

      if (!in_range) begin
         spin_after = 1'b0;
         acc_out    = 1'b0;
         de_out     = '0;
      end else if (is_load) begin
         spin_after = spin_ff;
         acc_out    = 1'b0;
         de_out     = '0;
      end else begin
         spin_after = acc ? ~centre : centre;
         acc_out    = acc;
         de_out     = de;
      end

      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '1;
      end else begin
         mem_we    = cmd.commit && in_range && (is_load || acc);
         mem_waddr = row_idx;
         mem_wdata = new_row;
      end
   end

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= {{(RSP_DATA_W - DE_W - 2){1'b0}}, de_out, acc_out, spin_after};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/core/ising_metropolis_spin_update.sv
// Top level of the Ising Metropolis spin update block.
// Joins ims_ctrl and ims_datapath; uses ims_pkg for types and constants.
//
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: kind; tdata: row, col, spin, draw
// rsp      out  rsp_tvalid/rsp_tready  tdata: spin_after, accepted, energy_change
// csr      in   csr_we                 csr_index, csr_wdata
//
// Each word passes through accept, two reads of the row-wide spin
// memory (site row and up row, then down row on port B), and one evaluate
// and write-back step; no new word is accepted until that write-back.
// A stalled result holds the evaluate step. After reset a clearing pass
// sets every spin to +1, one row a cycle, over all MAX_SIDE rows; no word is accepted meanwhile, csr writes are taken.
// Reset is synchronous and active high.
`timescale 1ns / 1ps

module ising_metropolis_spin_update #(
   parameter int MAX_SIDE = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,  // [0] req_type
   // [5:0] row, [11:6] col, [12] spin_value, [28:13] random_draw, [31:29] zero
   input  logic [ims_pkg::REQ_DATA_W-1:0]  req_tdata,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] spin_after, [1] accepted, [6:2] energy_change, [7] zero
   output logic [ims_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // configuration port
   input  logic                            csr_we,
   input  logic [ims_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ims_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ims_pkg::*;

   ims_cmd_type    cmd;
   ims_status_type status;

   // sequence the clearing pass, the reads and the commit
   ims_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hold the lattice, the registers and the result word
   ims_datapath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
